[sv/dmdr_pkg.sv]
package dmdr_pkg;

    // Header check values.
    localparam logic [7:0] VERSION     = 8'h03;
    localparam logic [7:0] INV_VERSION = 8'hFC;
    localparam logic [3:0] HDR_LEN     = 4'd8;

    // Payload types.
    localparam logic [15:0] PT_ROUTING_REQ  = 16'h0005;
    localparam logic [15:0] PT_ROUTING_RESP = 16'h0006;
    localparam logic [15:0] PT_ALIVE_REQ    = 16'h0007;
    localparam logic [15:0] PT_ALIVE_RESP   = 16'h0008;
    localparam logic [15:0] PT_DIAG         = 16'h8001;
    localparam logic [15:0] PT_DIAG_ACK     = 16'h8002;
    localparam logic [15:0] PT_DIAG_NACK    = 16'h8003;

    // Response and close codes.
    localparam logic [7:0] CODE_ROUTED      = 8'h10;
    localparam logic [7:0] NACK_NOT_ROUTED  = 8'h06;
    localparam logic [7:0] NACK_BAD_TARGET  = 8'h03;
    localparam logic [7:0] ACK_OK           = 8'h00;
    localparam logic [7:0] CLOSE_BAD_HEADER = 8'h00;
    localparam logic [7:0] CLOSE_TOO_LONG   = 8'h01;

    // Result kinds.
    localparam logic [1:0] KIND_RESPONSE = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_CLOSE    = 2'd2;

    // Output queue geometry.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] reply_type;
        logic [15:0] first_address;
        logic [15:0] second_address;
        logic [7:0]  reply_code;
        logic [7:0]  data_out;
        logic        last;
    } t_result;

    // Up to two results leave the engine for one byte, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
    } t_oq_status;

endpackage

[sv/dmdr_if.sv]
interface dmdr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface dmdr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] reply_type;
    logic [15:0] first_address;
    logic [15:0] second_address;
    logic [7:0]  reply_code;
    logic [7:0]  data_out;
    logic        last;

    modport source (
        output valid, output kind, output reply_type, output first_address,
        output second_address, output reply_code, output data_out, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input reply_type, input first_address,
        input second_address, input reply_code, input data_out, input last,
        output ready
    );
endinterface

interface dmdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] server_address;

    modport source (output valid, output server_address, input ready);
    modport sink (input valid, input server_address, output ready);
endinterface

[sv/dmdr_engine.sv]
module dmdr_engine #(
    parameter int MAX_MESSAGE = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_action,
    input  logic [7:0]     i_rx_byte,
    input  logic [15:0]    i_server_address,
    output logic           o_pending,
    output dmdr_pkg::t_push o_push
);
    import dmdr_pkg::*;

    localparam int          CNT_W   = $clog2(MAX_MESSAGE);
    localparam logic [16:0] MAX_LEN = 17'(MAX_MESSAGE - 8);

    // Input register.
    logic       r_valid;
    logic       r_action;
    logic [7:0] r_byte;

    // Connection state.
    logic             r_closed,  n_closed;
    logic [3:0]       r_hdr,     n_hdr;
    logic             r_vok,     n_vok;
    logic [15:0]      r_kind,    n_kind;
    logic             r_len_hi,  n_len_hi;
    logic [15:0]      r_len,     n_len;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [15:0]      r_src,     n_src;
    logic [15:0]      r_tgt,     n_tgt;
    logic             r_routed,  n_routed;
    logic [15:0]      r_client,  n_client;

    logic        fwd_v;
    t_result     fwd;
    logic        fin_v;
    t_result     fin;
    logic        fin_req;
    logic [16:0] cnt_next;

    always_comb begin
        n_closed = r_closed;
        n_hdr    = r_hdr;
        n_vok    = r_vok;
        n_kind   = r_kind;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_src    = r_src;
        n_tgt    = r_tgt;
        n_routed = r_routed;
        n_client = r_client;
        fwd_v    = 1'b0;
        fwd      = '0;
        fin_v    = 1'b0;
        fin      = '0;
        fin_req  = 1'b0;
        cnt_next = 17'(r_cnt) + 17'd1;
        o_push   = '0;

        if (r_valid) begin
            if (r_action) begin
                n_closed = 1'b0;
                n_hdr    = '0;
                n_vok    = 1'b0;
                n_kind   = '0;
                n_len_hi = 1'b0;
                n_len    = '0;
                n_cnt    = '0;
                n_src    = '0;
                n_tgt    = '0;
                n_routed = 1'b0;
                n_client = '0;
            end else if (!r_closed) begin
                if (r_hdr != HDR_LEN) begin
                    unique case (r_hdr)
                        4'd0: n_vok = (r_byte == VERSION);
                        4'd1: n_vok = r_vok && (r_byte == INV_VERSION);
                        4'd2: n_kind = {r_byte, 8'h00};
                        4'd3: n_kind = {r_kind[15:8], r_byte};
                        4'd4: begin
                            n_len_hi = (r_byte != 8'h00);
                            n_len    = '0;
                        end
                        4'd5: n_len_hi = r_len_hi || (r_byte != 8'h00);
                        4'd6: n_len = {r_byte, r_len[7:0]};
                        default: n_len = {r_len[15:8], r_byte};
                    endcase
                    n_hdr = r_hdr + 4'd1;
                    if (r_hdr == HDR_LEN - 4'd1) begin
                        if (!n_vok) begin
                            n_closed        = 1'b1;
                            fin_v           = 1'b1;
                            fin.kind        = KIND_CLOSE;
                            fin.reply_code  = CLOSE_BAD_HEADER;
                        end else if (n_len_hi || ({1'b0, n_len} > MAX_LEN)) begin
                            n_closed        = 1'b1;
                            fin_v           = 1'b1;
                            fin.kind        = KIND_CLOSE;
                            fin.reply_code  = CLOSE_TOO_LONG;
                        end else begin
                            n_cnt = '0;
                            n_src = '0;
                            n_tgt = '0;
                            if (n_len == 16'd0) begin
                                fin_req = 1'b1;
                            end
                        end
                    end
                end else begin
                    if (r_cnt == CNT_W'(0)) begin
                        n_src = {r_byte, 8'h00};
                    end else if (r_cnt == CNT_W'(1)) begin
                        n_src = {r_src[15:8], r_byte};
                    end else if (r_cnt == CNT_W'(2)) begin
                        n_tgt = {r_byte, 8'h00};
                    end else if (r_cnt == CNT_W'(3)) begin
                        n_tgt = {r_tgt[15:8], r_byte};
                    end else if (r_kind == PT_DIAG && r_routed
                                 && r_tgt == i_server_address) begin
                        fwd_v         = 1'b1;
                        fwd.kind      = KIND_DATA;
                        fwd.data_out  = r_byte;
                        fwd.last      = (cnt_next == {1'b0, r_len});
                    end
                    n_cnt = cnt_next[CNT_W-1:0];
                    if (cnt_next >= {1'b0, r_len}) begin
                        fin_req = 1'b1;
                    end
                end
            end
        end

        // Reply to a completed message.
        if (fin_req) begin
            case (n_kind)
                PT_ROUTING_REQ: begin
                    if (n_len >= 16'd7) begin
                        n_client            = n_src;
                        n_routed            = 1'b1;
                        fin_v               = 1'b1;
                        fin.kind            = KIND_RESPONSE;
                        fin.reply_type      = PT_ROUTING_RESP;
                        fin.first_address   = n_src;
                        fin.second_address  = i_server_address;
                        fin.reply_code      = CODE_ROUTED;
                    end
                end
                PT_ALIVE_REQ: begin
                    fin_v               = 1'b1;
                    fin.kind            = KIND_RESPONSE;
                    fin.reply_type      = PT_ALIVE_RESP;
                    fin.first_address   = i_server_address;
                end
                PT_DIAG: begin
                    if (!r_routed) begin
                        fin_v               = 1'b1;
                        fin.kind            = KIND_RESPONSE;
                        fin.reply_type      = PT_DIAG_NACK;
                        fin.first_address   = r_client;
                        fin.second_address  = i_server_address;
                        fin.reply_code      = NACK_NOT_ROUTED;
                    end else if (n_len >= 16'd4) begin
                        fin_v               = 1'b1;
                        fin.kind            = KIND_RESPONSE;
                        fin.first_address   = n_src;
                        fin.second_address  = n_tgt;
                        if (n_tgt != i_server_address) begin
                            fin.reply_type = PT_DIAG_NACK;
                            fin.reply_code = NACK_BAD_TARGET;
                        end else begin
                            fin.reply_type = PT_DIAG_ACK;
                            fin.reply_code = ACK_OK;
                        end
                    end
                end
                default: begin
                    fin_v = 1'b0;
                end
            endcase
            n_hdr = '0;
            n_vok = 1'b0;
            n_cnt = '0;
        end

        // The forwarded byte goes ahead of the acknowledge.
        if (fwd_v) begin
            o_push.res0  = fwd;
            o_push.res1  = fin;
            o_push.count = fin_v ? 2'd2 : 2'd1;
        end else begin
            o_push.res0  = fin;
            o_push.count = fin_v ? 2'd1 : 2'd0;
        end
    end

    assign o_pending = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_closed <= 1'b0;
            r_hdr    <= '0;
            r_vok    <= 1'b0;
            r_kind   <= '0;
            r_len_hi <= 1'b0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_src    <= '0;
            r_tgt    <= '0;
            r_routed <= 1'b0;
            r_client <= '0;
        end else begin
            r_valid  <= i_accept;
            r_closed <= n_closed;
            r_hdr    <= n_hdr;
            r_vok    <= n_vok;
            r_kind   <= n_kind;
            r_len_hi <= n_len_hi;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_src    <= n_src;
            r_tgt    <= n_tgt;
            r_routed <= n_routed;
            r_client <= n_client;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_action <= i_action;
            r_byte   <= i_rx_byte;
        end
    end

endmodule

[sv/dmdr_outq.sv]
module dmdr_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmdr_pkg::t_push       i_push,
    input  logic                  i_pop,
    output logic                  o_valid,
    output dmdr_pkg::t_result     o_head,
    output dmdr_pkg::t_oq_status  o_status
);
    import dmdr_pkg::*;

    t_result             r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr, n_wr;
    logic [OQ_PTR_W-1:0] r_rd, n_rd;
    logic [OQ_CNT_W-1:0] r_count, n_count;
    logic                pop;
    logic [OQ_PTR_W-1:0] wr_next;

    assign pop     = i_pop && (r_count != '0);
    assign wr_next = r_wr + OQ_PTR_W'(1);

    always_comb begin
        n_wr    = r_wr + OQ_PTR_W'(i_push.count);
        n_rd    = pop ? r_rd + OQ_PTR_W'(1) : r_rd;
        n_count = r_count + OQ_CNT_W'(i_push.count) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    assign o_valid        = (r_count != '0);
    assign o_head         = r_mem[r_rd];
    assign o_status.count = r_count;

endmodule

[sv/doip_message_deframer_responder.sv]
// DoIP TCP message deframer and responder for a single connection.
// The input channel carries one beat per received stream byte (action 0) or
// a new-connection beat (action 1) that clears all connection state but keeps
// the server address. The configuration channel writes the 16-bit server
// address; it is always ready and resets to 1.
// Each byte updates header and payload counters; at the end of a message the
// block may emit a response beat (routing activation, alive check, diagnostic
// ACK/NACK). Diagnostic data after the four address bytes, when routed to the
// server address, is forwarded beat by beat with the final byte marked, and the
// acknowledge follows it. A bad version pair or an oversize length emits a close
// beat and the block ignores bytes until the next new-connection beat.
// A result passes through the input register, where the response logic works on
// the byte, and then through the output queue before it can be taken.
// Throughput: one byte per cycle while input ready is high. A byte yields at most
// two results, so input ready falls once the queue count, plus two for a byte
// still held in the input register, would exceed six of the eight entries.
// When the receiver stalls the queue fills and input ready falls; nothing
// is lost. Synchronous active-low reset clears the queue and all state.
module doip_message_deframer_responder #(
    parameter int MAX_MESSAGE = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmdr_in_if.sink    i_in,
    dmdr_out_if.source o_out,
    dmdr_cfg_if.sink   i_cfg
);
    import dmdr_pkg::*;

    logic [15:0]         r_server_address;
    logic                accept;
    logic                pending;
    t_push               eng_push;
    t_result             head;
    t_oq_status          oq_status;
    logic [OQ_CNT_W:0]   load;

    // Configuration register, to be written only while the block is idle; the block itself does not enforce this.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_address <= 16'd1;
        end else if (i_cfg.valid) begin
            r_server_address <= i_cfg.server_address;
        end
    end

    // Queue occupancy plus the worst case of the byte in the input register.
    assign load       = {1'b0, oq_status.count} + (pending ? (OQ_CNT_W+1)'(2) : '0);
    assign i_in.ready = (load <= (OQ_CNT_W+1)'(OQ_DEPTH - 2));
    assign accept     = i_in.valid && i_in.ready;

    dmdr_engine #(
        .MAX_MESSAGE(MAX_MESSAGE)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_action        (i_in.action),
        .i_rx_byte       (i_in.rx_byte),
        .i_server_address(r_server_address),
        .o_pending       (pending),
        .o_push          (eng_push)
    );

    dmdr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (eng_push),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_status(oq_status)
    );

    assign o_out.kind           = head.kind;
    assign o_out.reply_type     = head.reply_type;
    assign o_out.first_address  = head.first_address;
    assign o_out.second_address = head.second_address;
    assign o_out.reply_code     = head.reply_code;
    assign o_out.data_out       = head.data_out;
    assign o_out.last           = head.last;

`ifndef NO_ASSERTIONS
    // The queue never holds more than its depth.
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_status.count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    // A new-connection beat never produces a result.
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.action) |=> (eng_push.count == 2'd0))
        else $error("result from a new-connection beat");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // Two results for one byte always start with a forwarded last data byte.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eng_push.count == 2'd2) |->
            (eng_push.res0.kind == KIND_DATA && eng_push.res0.last
             && eng_push.res1.kind == KIND_RESPONSE))
        else $error("bad result pair");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import dmdr_pkg::*;

    // Frame limits follow the block's default parameter.
    localparam int MAX_MESSAGE    = 4096;
    localparam int MAX_PAYLOAD    = MAX_MESSAGE - 8;

    // Run control.
    localparam int LONG_HOLD      = 200;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat on any channel
    localparam int SETTLE_CYCLES  = 6;     // settling beyond the result latency
    localparam int PHASE_BEATS    = 80;    // random beats per server address setting
    localparam int NUM_PHASES     = 5;

    // Results that can be read straight off the header, for the directed table.
    localparam t_result NO_RESULT        = '0;
    localparam t_result ALIVE_AT_RESET   = '{KIND_RESPONSE, PT_ALIVE_RESP, 16'h0001,
                                             16'h0000, ACK_OK, 8'h00, 1'b0};
    localparam t_result BAD_HEADER_CLOSE = '{KIND_CLOSE, 16'h0000, 16'h0000, 16'h0000,
                                             CLOSE_BAD_HEADER, 8'h00, 1'b0};
    localparam t_result TOO_LONG_CLOSE   = '{KIND_CLOSE, 16'h0000, 16'h0000, 16'h0000,
                                             CLOSE_TOO_LONG, 8'h00, 1'b0};

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       typed;
        t_result    want;
    } row_t;

    // Directed stimulus. A row with typed set must cause exactly the result given;
    // the other rows are left to the predictor.
    localparam row_t DIRECTED [26] = '{
        // Alive check with an empty payload, answered with the reset address.
        '{1'b0, VERSION,     1'b0, NO_RESULT},
        '{1'b0, INV_VERSION, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h07,       1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b1, ALIVE_AT_RESET},
        // A header of all ones fails the version check on its eighth byte.
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b0, NO_RESULT},
        '{1'b0, 8'hFF,       1'b1, BAD_HEADER_CLOSE},
        // The connection is closed now, so this byte is dropped silently.
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        // New connection.
        '{1'b1, 8'h00,       1'b0, NO_RESULT},
        // Payload length one above the limit closes the connection.
        '{1'b0, VERSION,     1'b0, NO_RESULT},
        '{1'b0, INV_VERSION, 1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h05,       1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h00,       1'b0, NO_RESULT},
        '{1'b0, 8'h0F,       1'b0, NO_RESULT},
        '{1'b0, 8'hF9,       1'b1, TOO_LONG_CLOSE}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dmdr_in_if  in_ch ();
    dmdr_out_if out_ch ();
    dmdr_cfg_if cfg_ch ();

    doip_message_deframer_responder #(
        .MAX_MESSAGE(MAX_MESSAGE)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a copy of the connection state and the server address.
    logic        conn_closed;
    int unsigned hdr_count;
    logic        version_good;
    logic [15:0] frame_type;
    logic [31:0] frame_len;
    logic [31:0] payload_seen;
    logic [15:0] src_word;
    logic [15:0] tgt_word;
    logic        is_routed;
    logic [15:0] client_word;
    logic [15:0] server_addr;

    // Results still owed by the block, oldest first, and those of the last beat.
    t_result pending_results [$];
    t_result beat_results [2];
    int      beat_count;

    // Bookkeeping.
    int      mismatches;
    int      stim_count;
    int      settings_used;
    int      results_checked;
    int      responses_seen;
    int      data_seen;
    int      closes_seen;
    t_result next_result;

    // Flow control knobs shared between the stimulus and the receiver.
    logic    tx_calm = 1'b0;
    logic    rx_calm = 1'b0;
    int      hold_requests = 0;
    int      holds_served;
    int      hold_left;
    int      stall_left;
    int      ready_pick;
    int      idle_cycles;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    function automatic t_result make_result(input logic [1:0] kind, input logic [15:0] rtype,
                                            input logic [15:0] first, input logic [15:0] second,
                                            input logic [7:0] code, input logic [7:0] data,
                                            input logic last);
        t_result r;
        r = '{kind, rtype, first, second, code, data, last};
        return r;
    endfunction

    function automatic void queue_result(input t_result r);
        beat_results[beat_count] = r;
        beat_count++;
        pending_results.push_back(r);
    endfunction

    // A new connection wipes everything but the server address.
    function automatic void clear_connection();
        conn_closed  = 1'b0;
        hdr_count    = 0;
        version_good = 1'b0;
        frame_type   = '0;
        frame_len    = '0;
        payload_seen = '0;
        src_word     = '0;
        tgt_word     = '0;
        is_routed    = 1'b0;
        client_word  = '0;
    endfunction

    // Reply owed once a whole message has been taken in.
    function automatic void answer_message();
        if (frame_type == PT_ROUTING_REQ) begin
            // Short routing requests are swallowed without an answer.
            if (frame_len >= 7) begin
                client_word = src_word;
                is_routed   = 1'b1;
                queue_result(make_result(KIND_RESPONSE, PT_ROUTING_RESP, src_word, server_addr,
                                         CODE_ROUTED, 8'h00, 1'b0));
            end
        end else if (frame_type == PT_ALIVE_REQ) begin
            queue_result(make_result(KIND_RESPONSE, PT_ALIVE_RESP, server_addr, 16'h0000,
                                     ACK_OK, 8'h00, 1'b0));
        end else if (frame_type == PT_DIAG) begin
            if (!is_routed) begin
                queue_result(make_result(KIND_RESPONSE, PT_DIAG_NACK, client_word, server_addr,
                                         NACK_NOT_ROUTED, 8'h00, 1'b0));
            end else if (frame_len >= 4) begin
                if (tgt_word != server_addr) begin
                    queue_result(make_result(KIND_RESPONSE, PT_DIAG_NACK, src_word, tgt_word,
                                             NACK_BAD_TARGET, 8'h00, 1'b0));
                end else begin
                    queue_result(make_result(KIND_RESPONSE, PT_DIAG_ACK, src_word, tgt_word,
                                             ACK_OK, 8'h00, 1'b0));
                end
            end
        end
        hdr_count    = 0;
        version_good = 1'b0;
        payload_seen = '0;
    endfunction

    // Predicts the results of one accepted input beat.
    function automatic void deframe_byte(input logic action, input logic [7:0] b);
        logic [31:0] idx;
        beat_count = 0;
        if (action) begin
            clear_connection();
            return;
        end
        if (conn_closed) begin
            return;
        end

        if (hdr_count < 8) begin
            case (hdr_count)
                0: version_good = (b == VERSION);
                1: version_good = version_good && (b == INV_VERSION);
                2: frame_type = {b, 8'h00};
                3: frame_type[7:0] = b;
                4: frame_len = {b, 24'h000000};
                5: frame_len[23:16] = b;
                6: frame_len[15:8] = b;
                default: frame_len[7:0] = b;
            endcase
            hdr_count++;
            if (hdr_count < 8) begin
                return;
            end
            // The version check wins over the length check.
            if (!version_good) begin
                conn_closed = 1'b1;
                queue_result(make_result(KIND_CLOSE, 16'h0000, 16'h0000, 16'h0000,
                                         CLOSE_BAD_HEADER, 8'h00, 1'b0));
                return;
            end
            if (frame_len > MAX_PAYLOAD) begin
                conn_closed = 1'b1;
                queue_result(make_result(KIND_CLOSE, 16'h0000, 16'h0000, 16'h0000,
                                         CLOSE_TOO_LONG, 8'h00, 1'b0));
                return;
            end
            payload_seen = '0;
            src_word     = '0;
            tgt_word     = '0;
            if (frame_len == 0) begin
                answer_message();
            end
            return;
        end

        // Payload: four address bytes, then data that may be forwarded.
        idx = payload_seen;
        if (idx == 0) begin
            src_word = {b, 8'h00};
        end else if (idx == 1) begin
            src_word[7:0] = b;
        end else if (idx == 2) begin
            tgt_word = {b, 8'h00};
        end else if (idx == 3) begin
            tgt_word[7:0] = b;
        end else if (frame_type == PT_DIAG && is_routed && tgt_word == server_addr) begin
            queue_result(make_result(KIND_DATA, 16'h0000, 16'h0000, 16'h0000, 8'h00, b,
                                     (idx + 1 == frame_len)));
        end
        payload_seen = idx + 1;
        if (payload_seen >= frame_len) begin
            answer_message();
        end
    endfunction

    // Sender gaps: mostly none, some short, a few long; none at all when calm.
    function automatic int sender_gap();
        int pick;
        if (tx_calm) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 0;
        end
        if (pick < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Drives one beat at the falling edge, holds it until accepted at a rising
    // edge, and predicts its results at that edge.
    task automatic send_beat(input logic action, input logic [7:0] rx);
        int gap;
        gap = sender_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid   = 1'b1;
        in_ch.action  = action;
        in_ch.rx_byte = rx;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        // Bytes dropped on a closed connection do not count as stimulus.
        if (action || !conn_closed) begin
            stim_count++;
        end
        deframe_byte(action, rx);
    endtask

    task automatic send_header(input logic [7:0] ver, input logic [7:0] inv_ver,
                               input logic [15:0] ptype, input logic [31:0] len);
        send_beat(1'b0, ver);
        send_beat(1'b0, inv_ver);
        send_beat(1'b0, ptype[15:8]);
        send_beat(1'b0, ptype[7:0]);
        send_beat(1'b0, len[31:24]);
        send_beat(1'b0, len[23:16]);
        send_beat(1'b0, len[15:8]);
        send_beat(1'b0, len[7:0]);
    endtask

    // A well-formed message; it may be cut short by a new connection beat.
    task automatic send_message(input logic [15:0] ptype, input logic [31:0] len,
                                input logic [15:0] src, input logic [15:0] tgt,
                                input logic may_abort);
        logic [7:0] b;
        int         abort_at;
        if (may_abort && len != 0 && $urandom_range(0, 29) == 0) begin
            abort_at = $urandom_range(0, len - 1);
        end else begin
            abort_at = -1;
        end
        send_header(VERSION, INV_VERSION, ptype, len);
        for (int i = 0; i < int'(len); i++) begin
            if (i == abort_at) begin
                send_beat(1'b1, 8'($urandom));
                return;
            end
            case (i)
                0: b = src[15:8];
                1: b = src[7:0];
                2: b = tgt[15:8];
                3: b = tgt[7:0];
                default: b = 8'($urandom);
            endcase
            send_beat(1'b0, b);
        end
    endtask

    // One random message. Most are well formed, so that routing and forwarding
    // are reached; the rest are broken headers, oversize lengths and noise.
    task automatic send_random_message();
        int          pick;
        logic [15:0] tgt;
        logic [31:0] len;
        // Get back in step after a close or a stray byte.
        if (conn_closed || hdr_count != 0) begin
            if (conn_closed) begin
                repeat ($urandom_range(0, 2)) send_beat(1'b0, 8'($urandom));
            end
            send_beat(1'b1, 8'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 11);
            send_message(PT_ROUTING_REQ, len, 16'($urandom), 16'($urandom), 1'b1);
        end else if (pick < 34) begin
            send_message(PT_ALIVE_REQ, $urandom_range(0, 3), 16'($urandom), 16'($urandom),
                         1'b1);
        end else if (pick < 72) begin
            // Usually route first, so that most diagnostic traffic gets through.
            if (!is_routed && $urandom_range(0, 2) != 0) begin
                send_message(PT_ROUTING_REQ, 7 + $urandom_range(0, 4), 16'($urandom),
                             16'($urandom), 1'b1);
            end
            tgt  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : server_addr;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                len = $urandom_range(0, 3);
            end else if (pick < 93) begin
                len = 4 + $urandom_range(0, 12);
            end else begin
                len = 4 + $urandom_range(13, 40);
            end
            send_message(PT_DIAG, len, 16'($urandom), tgt, 1'b1);
        end else if (pick < 80) begin
            send_message(16'($urandom), $urandom_range(0, 6), 16'($urandom), 16'($urandom),
                         1'b1);
        end else if (pick < 86) begin
            // One wrong bit in either version byte.
            if ($urandom_range(0, 1) == 1) begin
                send_header(VERSION ^ (8'd1 << $urandom_range(0, 7)), INV_VERSION,
                            16'($urandom), $urandom);
            end else begin
                send_header(VERSION, INV_VERSION ^ (8'd1 << $urandom_range(0, 7)),
                            16'($urandom), $urandom);
            end
        end else if (pick < 91) begin
            if ($urandom_range(0, 1) == 1) begin
                len = MAX_PAYLOAD + 1 + $urandom_range(0, 100);
            end else begin
                len = $urandom | 32'h0001_0000;
            end
            send_header(VERSION, INV_VERSION, 16'($urandom), len);
        end else if (pick < 95) begin
            send_beat(1'b1, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) send_beat(1'b0, 8'($urandom));
        end
    endtask

    // Route, then send a diagnostic message with a long data part while the
    // receiver holds off, so the output queue fills and input ready falls.
    task automatic pressure_burst();
        send_beat(1'b1, 8'($urandom));
        send_message(PT_ROUTING_REQ, 7, 16'($urandom), 16'($urandom), 1'b0);
        hold_requests++;
        send_message(PT_DIAG, 44, 16'($urandom), server_addr, 1'b0);
    endtask

    // The register is written only with the input idle, all results in, and
    // enough extra cycles for a beat that owes nothing to clear the pipeline.
    task automatic write_server(input logic [15:0] value);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid          = 1'b1;
        cfg_ch.server_address = value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        server_addr = value;
        settings_used++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
        end
    endtask

    // Result monitor: every accepted result beat is matched against the
    // oldest result still owed.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat of kind %0d with nothing expected",
                                          out_ch.kind));
            end else begin
                next_result = pending_results.pop_front();
                check_field("kind", 16'(out_ch.kind), 16'(next_result.kind));
                check_field("reply_type", out_ch.reply_type, next_result.reply_type);
                check_field("first_address", out_ch.first_address, next_result.first_address);
                check_field("second_address", out_ch.second_address,
                            next_result.second_address);
                check_field("reply_code", 16'(out_ch.reply_code), 16'(next_result.reply_code));
                check_field("data_out", 16'(out_ch.data_out), 16'(next_result.data_out));
                check_field("last", 16'(out_ch.last), 16'(next_result.last));
                results_checked++;
                if (next_result.kind == KIND_RESPONSE) begin
                    responses_seen++;
                end else if (next_result.kind == KIND_DATA) begin
                    data_seen++;
                end else begin
                    closes_seen++;
                end
            end
        end
    end

    // Receiver: random stalls, mostly short, a few long, none when calm. A
    // hold-off request from the stimulus turns into a long stretch of ready
    // low, counted here.
    initial begin
        out_ch.ready = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready = 1'b0;
            end else if (rx_calm) begin
                out_ch.ready = 1'b1;
            end else begin
                ready_pick = $urandom_range(0, 99);
                if (ready_pick < 75) begin
                    out_ch.ready = 1'b1;
                end else begin
                    out_ch.ready = 1'b0;
                    stall_left   = (ready_pick < 96) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40);
                end
            end
        end
    end

    // Watchdog: the run is stuck once no channel has moved a beat for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("doip_message_deframer_responder: mismatch");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        logic [15:0] addr;
        in_ch.valid           = 1'b0;
        in_ch.action          = 1'b0;
        in_ch.rx_byte         = 8'h00;
        cfg_ch.valid          = 1'b0;
        cfg_ch.server_address = 16'h0000;
        mismatches            = 0;
        stim_count            = 0;
        settings_used         = 1;
        results_checked       = 0;
        responses_seen        = 0;
        data_seen             = 0;
        closes_seen           = 0;
        server_addr           = 16'h0001;
        clear_connection();

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: header extremes, the close cases and a new connection.
        for (int r = 0; r < $size(DIRECTED); r++) begin
            send_beat(DIRECTED[r].action, DIRECTED[r].rx_byte);
            if (DIRECTED[r].typed &&
                (beat_count != 1 || beat_results[0] !== DIRECTED[r].want)) begin
                report_mismatch($sformatf("directed row %0d: predicted %h, table gives %h",
                                          r, beat_results[0], DIRECTED[r].want));
            end
        end

        // Random phases under several server addresses. The first keeps the reset
        // value; the others cover both extremes, a random address and the reset value.
        stim_count = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: write_server(16'h0000);
                2: write_server(16'hFFFF);
                3: begin
                    addr = 16'($urandom);
                    write_server(addr);
                end
                4: write_server(16'h0001);
                default: ;
            endcase
            tx_calm = (p == 2);
            rx_calm = (p == 3);
            if (p == 1) begin
                pressure_burst();
            end
            while (stim_count < (p + 1) * PHASE_BEATS) begin
                send_random_message();
            end
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES + 4) @(posedge i_clk);

        $display("Drove %0d counted input beats under %0d server addresses, with %0d hold-off.",
                 stim_count, settings_used, hold_requests);
        $display("Checked %0d results: %0d replies, %0d forwarded bytes, %0d closes.",
                 results_checked, responses_seen, data_seen, closes_seen);
        if (mismatches == 0) begin
            $display("doip_message_deframer_responder: match");
        end else begin
            $display("doip_message_deframer_responder: mismatch");
        end
        $finish;
    end

endmodule

[doip_message_deframer_responder.f]
sv/dmdr_pkg.sv
sv/dmdr_if.sv
sv/dmdr_engine.sv
sv/dmdr_outq.sv
sv/doip_message_deframer_responder.sv
verif/testbench.sv
